/* hw/rtl/sem_pkg.sv */
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 13;
  localparam int ROW_W     = 13;
  localparam int PIX_W     = 24;
  // gx^2 + gy^2 reaches 2 * 1020^2
  localparam int SUM_W     = 22;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // Window snapshot with border masks, handed from the front part to the back part
  typedef struct packed {
    logic [PIX_W-1:0] p0, p1, p2, p3, p4, p5, p6, p7, p8;
    logic [2:0]       rv;
    logic [2:0]       cv;
    logic             last;
  } win_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } res_t;

endpackage

/* hw/rtl/sem_ram.sv */
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/sem_front.sv */
// Front part: frame position, line stores and the 3x3 window.
// Each pixel or flush item: line store read, then window update.
module sem_front import sem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [HGT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_drain,
  input  logic [PIX_W-1:0] in_pix,
  output logic             win_valid,
  input  logic             win_ready,
  output win_t             win
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic [WID_W-1:0] frame_width;
  logic [HGT_W-1:0] frame_height;
  logic [WID_W-1:0] w;
  logic [HGT_W-1:0] h;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [WID_W-1:0] pending;
  logic             state;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] up_rd, lo_rd;
  logic [PIX_W-1:0] wp [9];
  logic [2:0]       border_rv;
  logic [2:0]       border_cv;
  logic             last_tap;
  logic [COL_W-1:0] col;
  logic             ram_we;

  // effective sizes
  always_comb begin
    if (frame_width == '0) begin
      w = WID_W'(1);
    end else if (frame_width > WID_W'(MAX_WIDTH)) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = frame_width;
    end
    h = (frame_height == '0) ? HGT_W'(1) : frame_height;
  end

  assign col      = ({1'b0, column_count} >= w) ? '0 : column_count;
  assign in_ready = (state == ST_IDLE) && !win_valid;
  assign ram_we   = (state == ST_UPD);

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(col), .wdata(lo_rd),
    .re(in_valid && in_ready), .raddr(col), .rdata(up_rd)
  );
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk(clk), .we(ram_we), .waddr(col), .wdata(pix),
    .re(in_valid && in_ready), .raddr(col), .rdata(lo_rd)
  );

  // sequencer, position and window
  always_ff @(posedge clk) begin
    logic [WID_W:0]   cn;
    logic [ROW_W-1:0] rn;
    logic [WID_W-1:0] tc;
    logic [ROW_W-1:0] tr;
    if (rst) begin
      frame_width  <= WID_W'(640);
      frame_height <= HGT_W'(480);
      column_count <= '0;
      row_count    <= '0;
      pending      <= '0;
      state        <= ST_IDLE;
      win_valid    <= 1'b0;
      for (int i = 0; i < 9; i++) wp[i] <= '0;
    end else begin
      if (win_valid && win_ready) begin
        win_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) begin
          frame_width <= cfg_data[WID_W-1:0];
        end else begin
          frame_height <= cfg_data;
        end
        column_count <= '0;
        row_count    <= '0;
        pending      <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready && !(in_drain && pending == '0)) begin
            pix   <= (pending == '0) ? in_pix : '0;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          state <= ST_IDLE;
          for (int r = 0; r < 3; r++) begin
            wp[r*3]   <= wp[r*3+1];
            wp[r*3+1] <= wp[r*3+2];
          end
          wp[2] <= up_rd;
          wp[5] <= lo_rd;
          wp[8] <= pix;
          cn = {1'b0, WID_W'(col)} + 1'b1;
          rn = row_count;
          if (cn >= {1'b0, w}) begin
            cn = '0;
            rn = row_count + 1'b1;
          end
          column_count <= cn[COL_W-1:0];
          row_count    <= rn;
          if (pending != '0) begin
            pending <= pending - 1'b1;
            if (pending == WID_W'(1)) begin
              column_count <= '0;
              row_count    <= '0;
            end
          end else if (rn == h && cn == '0) begin
            pending <= w + 1'b1;
          end
          if (col != '0) begin
            tc = WID_W'(col) - 1'b1;
            tr = row_count - 1'b1;
          end else begin
            tc = w - 1'b1;
            tr = (row_count >= ROW_W'(2)) ? row_count - ROW_W'(2) : '0;
          end
          if (row_count >= ROW_W'(2) || (row_count == ROW_W'(1) && col != '0)) begin
            win_valid <= 1'b1;
          end
          border_rv <= {tr + 1'b1 < h, 1'b1, tr != '0};
          border_cv <= {tc + 1'b1 < w, 1'b1, tc != '0};
          last_tap  <= (tr == h - 1'b1) && (tc == w - 1'b1);
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // window as seen after the shift
  always_comb begin
    win.p0 = wp[0]; win.p1 = wp[1]; win.p2 = wp[2];
    win.p3 = wp[3]; win.p4 = wp[4]; win.p5 = wp[5];
    win.p6 = wp[6]; win.p7 = wp[7]; win.p8 = wp[8];
    win.rv   = border_rv;
    win.cv   = border_cv;
    win.last = last_tap;
  end
endmodule

/* hw/rtl/sem_back.sv */
// Back part: Sobel sums, then an iterative rounded root, one result bit per cycle
// for the three channels in parallel.
module sem_back import sem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic win_valid,
  output logic win_ready,
  input  win_t win,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state;
  logic [3:0]        step;
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic [SUM_W-1:0]  s  [3];
  logic [8:0]        r  [3];
  logic              last;

  function automatic logic signed [11:0] px(input logic [PIX_W-1:0] p, input int c,
                                           input logic m);
    return m ? 12'(signed'({4'b0, p[c*8 +: 8]})) : 12'sd0;
  endfunction

  assign win_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    logic signed [11:0] a [9];
    logic [SUM_W-1:0] t;
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (win_valid) begin
            for (int c = 0; c < 3; c++) begin
              a[0] = px(win.p0, 2-c, win.rv[0] & win.cv[0]);
              a[1] = px(win.p1, 2-c, win.rv[0]);
              a[2] = px(win.p2, 2-c, win.rv[0] & win.cv[2]);
              a[3] = px(win.p3, 2-c, win.cv[0]);
              a[5] = px(win.p5, 2-c, win.cv[2]);
              a[6] = px(win.p6, 2-c, win.rv[2] & win.cv[0]);
              a[7] = px(win.p7, 2-c, win.rv[2]);
              a[8] = px(win.p8, 2-c, win.rv[2] & win.cv[2]);
              gx[c] <= 12'(a[2] - a[0] + 12'sd2 * (a[5] - a[3]) + a[8] - a[6]);
              gy[c] <= 12'(a[6] - a[0] + 12'sd2 * (a[7] - a[1]) + a[8] - a[2]);
            end
            last  <= win.last;
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          // squares formed at 24 bits, all positive
          for (int c = 0; c < 3; c++) begin
            s[c] <= SUM_W'(24'(gx[c]) * 24'(gx[c])) + SUM_W'(24'(gy[c]) * 24'(gy[c]));
            r[c] <= '0;
          end
          step  <= 4'd8;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          // bit-by-bit root; last pass applies rounding and saturation
          for (int c = 0; c < 3; c++) begin
            if (step != 4'd0) begin
              t = SUM_W'(r[c] | (9'd1 << (step - 1'b1)));
              if (t * t <= s[c]) r[c] <= t[8:0];
            end else begin
              t = SUM_W'(r[c]) * SUM_W'(r[c]) + SUM_W'(r[c]);
              if (s[c] >= SUM_W'(65281)) r[c] <= 9'd255;
              else if (s[c] > t) r[c] <= (r[c] >= 9'd255) ? 9'd255 : r[c] + 1'b1;
            end
          end
          if (step == 4'd0) state <= ST_OUT;
          else step <= step - 1'b1;
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.red   = r[0][7:0];
  assign res.green = r[1][7:0];
  assign res.blue  = r[2][7:0];
  assign res.last  = last;
endmodule

/* hw/rtl/sobel_edge_magnitude_rgb.sv */
// 3x3 Sobel edge magnitude on RGB pixels in raster order. Each item passes a
// line store read and a window update in the front part; a drain beat outside
// a flush is taken and dropped. The back part forms each result with the
// bit-serial rounded root and takes no new window until the result is taken;
// the front part takes no new item while a window waits. The result for pixel
// p leaves with item p+width+1; send width+1 drain items after the last pixel.
// A register write restarts the frame.
module sobel_edge_magnitude_rgb import sem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // edge_red, edge_green, edge_blue
  output logic        m_axis_tlast
);
  logic win_valid, win_ready;
  win_t win;
  res_t res;

  assign cfg_ready = 1'b1;

  sem_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data[HGT_W-1:0]),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_drain(s_axis_tuser),
    .in_pix({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .win_valid(win_valid), .win_ready(win_ready), .win(win)
  );

  sem_back u_back (
    .clk(clk), .rst(rst),
    .win_valid(win_valid), .win_ready(win_ready), .win(win),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {res.blue, res.green, res.red};
  assign m_axis_tlast = res.last;
endmodule
